// File: sv/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg: shared definitions for the damped feedback echo
// Holds the coefficient format, the configuration register map with its reset
// values, the control state encoding and the coefficient clamp.
// ----------------------------------------------------------------------------
package dfe_pkg;

	// Coefficients are unsigned Q1.15 where COEF_ONE stands for 1.0.
	localparam int COEF_SHIFT = 15;
	localparam int COEF_BITS = 16;
	localparam logic [COEF_BITS:0] COEF_ONE = 17'd32768;

	// Configuration port layout.
	localparam int DELAY_BITS = 17;
	localparam int CFG_DATA_BITS = 17;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_SAMPLES = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_GAIN = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WET_MIX = 2'd3;

	localparam logic [DELAY_BITS-1:0] RST_DELAY_SAMPLES = 17'd24000;
	localparam logic [COEF_BITS-1:0] RST_DECAY_GAIN = 16'd13107;
	localparam logic [COEF_BITS-1:0] RST_DAMPING = 16'd6554;
	localparam logic [COEF_BITS-1:0] RST_WET_MIX = 16'd32768;

	// Sequencer states of the feedback loop.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_FILT,
		ST_GAIN,
		ST_FB
	} dfe_state_t;

	// A coefficient above one acts as exactly one.
	function automatic logic [COEF_BITS:0] clamp_coef(input logic [COEF_BITS-1:0] c);
		logic [COEF_BITS:0] ext;
		ext = {1'b0, c};
		return (ext > COEF_ONE) ? COEF_ONE : ext;
	endfunction

endpackage

// File: sv/dfe_delay_ram.sv
// ----------------------------------------------------------------------------
// dfe_delay_ram: echo delay line storage
// Simple dual-port synchronous memory with one write and one registered read
// per cycle, write-to-read forwarding on a same-address collision, and a fill
// mark that makes never-written entries read as zero.
// ----------------------------------------------------------------------------
module dfe_delay_ram #(
	parameter int DEPTH = 65536,
	parameter int DATA_BITS = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic signed [DATA_BITS-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic signed [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DATA_BITS-1:0] ram_q;
	logic [AW-1:0]        fill_q;
	logic                 zero_wr_q;
	logic                 hit_s1;
	logic                 fwd_s1;
	logic [DATA_BITS-1:0] fwd_data_s1;
	logic                 rd_written;

	// Storage array with one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q <= mem[rd_addr];
		end
	end

	// The ring only ever steps by one or wraps to zero, so the nonzero
	// entries written so far are always one through fill_q.
	assign rd_written = (rd_addr == '0) ? zero_wr_q : (rd_addr <= fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			zero_wr_q <= 1'b0;
			hit_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_addr == '0) begin
					zero_wr_q <= 1'b1;
				end else if (wr_addr > fill_q) begin
					fill_q <= wr_addr;
				end
			end
			if (rd_en) begin
				hit_s1 <= rd_written;
				fwd_s1 <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// Forwarded write data for a read of the entry being written.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			rd_data = $signed(fwd_data_s1);
		end else if (hit_s1) begin
			rd_data = $signed(ram_q);
		end else begin
			rd_data = '0;
		end
	end

endmodule

// File: sv/dfe_mix_stage.sv
// ----------------------------------------------------------------------------
// dfe_mix_stage: wet and dry output mix
// Elastic three-register pipeline: operand capture, the two mix products,
// then the saturated sum in the output register that drives the channel.
// ----------------------------------------------------------------------------
module dfe_mix_stage #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          push_ready,
	input  logic signed [SAMPLE_BITS-1:0] fb,
	input  logic signed [SAMPLE_BITS-1:0] dry,
	input  logic [dfe_pkg::COEF_BITS:0]   wet,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	import dfe_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + COEF_BITS + 2;
	localparam int SSW = SB + 4;
	localparam logic signed [SSW-1:0] SMAX = {5'b00000, {(SB-1){1'b1}}};
	localparam logic signed [SSW-1:0] SMIN = {5'b11111, {(SB-1){1'b0}}};

	function automatic logic signed [SB-1:0] sat(input logic signed [SSW-1:0] v);
		logic signed [SB-1:0] r;
		if (v > SMAX) begin
			r = SMAX[SB-1:0];
		end else if (v < SMIN) begin
			r = SMIN[SB-1:0];
		end else begin
			r = v[SB-1:0];
		end
		return r;
	endfunction

	logic                 v_s1;
	logic signed [SB-1:0] fb_s1;
	logic signed [SB-1:0] dry_s1;
	logic                 v_s2;
	logic signed [PW-1:0] prod_w_s2;
	logic signed [PW-1:0] prod_d_s2;
	logic                 out_valid_q;
	logic signed [SB-1:0] sample_out_q;

	logic                 out_free;
	logic                 adv2;
	logic                 adv1;
	logic signed [COEF_BITS+1:0] wet_s;
	logic signed [COEF_BITS+1:0] dry_c;
	logic signed [PW-1:0] sh_w;
	logic signed [PW-1:0] sh_d;
	logic signed [SSW-1:0] mix_sum;

	// Stage advance: each register moves when the one after it has room.
	assign out_free = !out_valid_q || !out_stall;
	assign adv2 = v_s2 && out_free;
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign push_ready = !v_s1 || adv1;

	assign wet_s = $signed({1'b0, wet});
	assign dry_c = $signed({1'b0, COEF_ONE - wet});

	// Products are floored by the coefficient scale, then summed and saturated.
	assign sh_w = prod_w_s2 >>> COEF_SHIFT;
	assign sh_d = prod_d_s2 >>> COEF_SHIFT;
	assign mix_sum = $signed(sh_w[SSW-1:0]) + $signed(sh_d[SSW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_ready) begin
				v_s1 <= push;
			end
			if (!v_s2 || adv2) begin
				v_s2 <= adv1;
			end
			if (out_free) begin
				out_valid_q <= adv2;
			end
		end
	end

	// Payload registers follow their valid bits.
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			fb_s1 <= fb;
			dry_s1 <= dry;
		end
		if (adv1) begin
			prod_w_s2 <= wet_s * fb_s1;
			prod_d_s2 <= dry_c * dry_s1;
		end
		if (adv2) begin
			sample_out_q <= sat(mix_sum);
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

// File: sv/damped_feedback_echo_core.sv
// ----------------------------------------------------------------------------
// damped_feedback_echo_core: feedback echo with one-pole damping
// Ring-buffer echo: the delayed sample is low-pass filtered, scaled by the
// decay gain, added to the input and written back; the output mixes the
// feedback value with the dry input.
// ----------------------------------------------------------------------------
// Usage:
// Input requests carry one signed sample on sample_in and are taken when
// in_valid is high and in_stall is low. Each request yields exactly one
// output request on sample_out, held with out_valid until out_stall is low.
// Configuration registers (delay_samples, decay_gain, damping, wet_mix) are
// written through cfg_write_en, cfg_index and cfg_data while the block is
// idle.
// Each accepted sample runs through one delay-memory read, the two filter
// products, the filter sum, the decay product and the saturated feedback
// write-back, with the write and the next read sharing a cycle and forwarded
// on a same-entry collision. A new sample is taken only in the write-back
// step or when idle. The mix runs in its own pipeline after the loop.
// Reset clears the ring position and the filter state and returns the
// configuration registers to their default values.
// The delay memory reads as zero wherever it has not been written since
// reset, tracked by a fill mark, so no clearing pass is needed.
// When the receiver stalls, the output register holds its request; the mix
// pipeline fills, after which the loop holds its last step and in_stall rises.
// ----------------------------------------------------------------------------
module damped_feedback_echo_core #(
	parameter int DELAY_DEPTH = 65536,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [dfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dfe_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]     sample_out
);
	import dfe_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int LW = $clog2(DELAY_DEPTH + 1);
	localparam int CW = (LW > DELAY_BITS) ? LW : DELAY_BITS;
	localparam int PW = SB + COEF_BITS + 2;
	localparam int SSW = SB + 4;
	localparam logic signed [SSW-1:0] SMAX = {5'b00000, {(SB-1){1'b1}}};
	localparam logic signed [SSW-1:0] SMIN = {5'b11111, {(SB-1){1'b0}}};
	localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);

	function automatic logic signed [SB-1:0] sat(input logic signed [SSW-1:0] v);
		logic signed [SB-1:0] r;
		if (v > SMAX) begin
			r = SMAX[SB-1:0];
		end else if (v < SMIN) begin
			r = SMIN[SB-1:0];
		end else begin
			r = v[SB-1:0];
		end
		return r;
	endfunction

	dfe_state_t state_q;
	dfe_state_t state_d;

	logic [DELAY_BITS-1:0] delay_q;
	logic [COEF_BITS-1:0]  decay_q;
	logic [COEF_BITS-1:0]  damp_q;
	logic [COEF_BITS-1:0]  wet_q;

	logic [AW-1:0]         pos_q;
	logic signed [SB-1:0]  x_q;
	logic signed [SB-1:0]  filt_mem_q;
	logic signed [PW-1:0]  prod_a_s1;
	logic signed [PW-1:0]  prod_b_s1;
	logic signed [PW-1:0]  prod_g_s1;

	logic [CW-1:0]         delay_ext;
	logic [CW-1:0]         len_w;
	logic [CW-1:0]         next_w;
	logic [AW-1:0]         next_pos;
	logic [COEF_BITS:0]    damp_c;
	logic [COEF_BITS:0]    decay_c;
	logic [COEF_BITS:0]    wet_c;
	logic signed [COEF_BITS+1:0] damp_s;
	logic signed [COEF_BITS+1:0] undamp_s;
	logic signed [COEF_BITS+1:0] decay_s;
	logic signed [SB-1:0]  delayed;
	logic signed [PW-1:0]  sh_a;
	logic signed [PW-1:0]  sh_b;
	logic signed [PW-1:0]  sh_g;
	logic signed [SSW-1:0] filt_sum;
	logic signed [SSW-1:0] fb_sum;
	logic signed [SB-1:0]  fb;

	logic                  accept;
	logic                  ram_wr;
	logic                  tail_push;
	logic                  tail_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RST_DELAY_SAMPLES;
			decay_q <= RST_DECAY_GAIN;
			damp_q <= RST_DAMPING;
			wet_q <= RST_WET_MIX;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_DELAY_SAMPLES: delay_q <= cfg_data;
				REG_DECAY_GAIN: decay_q <= cfg_data[COEF_BITS-1:0];
				REG_DAMPING: damp_q <= cfg_data[COEF_BITS-1:0];
				REG_WET_MIX: wet_q <= cfg_data[COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective coefficients and delay length.
	assign damp_c = clamp_coef(damp_q);
	assign decay_c = clamp_coef(decay_q);
	assign wet_c = clamp_coef(wet_q);
	assign damp_s = $signed({1'b0, damp_c});
	assign undamp_s = $signed({1'b0, COEF_ONE - damp_c});
	assign decay_s = $signed({1'b0, decay_c});

	assign delay_ext = CW'(delay_q);
	always_comb begin
		if (delay_ext == '0) begin
			len_w = CW'(1);
		end else if (delay_ext > DEPTH_C) begin
			len_w = DEPTH_C;
		end else begin
			len_w = delay_ext;
		end
	end

	// Ring advance: wrap to zero once the length is reached or passed.
	assign next_w = CW'(pos_q) + CW'(1);
	assign next_pos = (next_w >= len_w) ? '0 : next_w[AW-1:0];

	// Delay line storage.
	dfe_delay_ram #(
		.DEPTH(DELAY_DEPTH),
		.DATA_BITS(SB)
	) u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(next_pos),
		.rd_data(delayed),
		.wr_en(ram_wr),
		.wr_addr(pos_q),
		.wr_data(fb)
	);

	// Filter sum and feedback sum, each floored then saturated.
	assign sh_a = prod_a_s1 >>> COEF_SHIFT;
	assign sh_b = prod_b_s1 >>> COEF_SHIFT;
	assign sh_g = prod_g_s1 >>> COEF_SHIFT;
	assign filt_sum = $signed(sh_a[SSW-1:0]) + $signed(sh_b[SSW-1:0]);
	assign fb_sum = $signed(sh_g[SSW-1:0]) + $signed({{4{x_q[SB-1]}}, x_q});
	assign fb = sat(fb_sum);

	// Next state of the loop sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: state_d = ST_FILT;
			ST_FILT: state_d = ST_GAIN;
			ST_GAIN: state_d = ST_FB;
			ST_FB: begin
				if (tail_ready) begin
					state_d = in_valid ? ST_PROD : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = 1'b1;
		ram_wr = 1'b0;
		tail_push = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_FB: begin
				in_stall = !tail_ready;
				ram_wr = tail_ready;
				tail_push = tail_ready;
			end
			default: in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			filt_mem_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pos_q <= next_pos;
			end
			if (state_q == ST_FILT) begin
				filt_mem_q <= sat(filt_sum);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
		end
		if (state_q == ST_PROD) begin
			prod_a_s1 <= undamp_s * delayed;
			prod_b_s1 <= damp_s * filt_mem_q;
		end
		if (state_q == ST_GAIN) begin
			prod_g_s1 <= decay_s * filt_mem_q;
		end
	end

	// Output mix pipeline.
	dfe_mix_stage #(
		.SAMPLE_BITS(SB)
	) u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.push(tail_push),
		.push_ready(tail_ready),
		.fb(fb),
		.dry(x_q),
		.wet(wet_c),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out)
	);

`ifndef SYNTHESIS
	// An accepted sample always starts with the product step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_PROD)
		else $error("accepted sample did not enter the product step");

	// The ring position moves only when a sample is accepted.
	a_pos_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pos_q) |-> $past(accept))
		else $error("ring position moved without an accepted sample");

	// The filter state changes only after the filter sum step.
	a_filt_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(filt_mem_q) |-> $past(state_q) == ST_FILT)
		else $error("filter state changed outside the filter step");

	// A full mix pipeline holds the write-back step and its memory write.
	a_fb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FB && !tail_ready) |-> (!ram_wr ##1 state_q == ST_FB))
		else $error("write-back step left while the mix pipeline was full");
`endif

endmodule
